@@ rtl/core/ordered_list_append_delete_assert.svh @@
// Assertion macros used by the ordered list datapath.
`ifndef ORDERED_LIST_APPEND_DELETE_ASSERT_SVH
`define ORDERED_LIST_APPEND_DELETE_ASSERT_SVH

// Check a property on every clock edge outside reset.
`define OLAD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check that a condition never holds outside reset.
`define OLAD_ASSERT_NEVER(label, expr, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);

`endif

@@ rtl/core/olad_pkg.sv @@
// Types and constants shared by the ordered list modules.
package olad_pkg;

  localparam int unsigned OLAD_DEPTH = 16;
  localparam int unsigned DATA_W     = 32;

  typedef enum logic [1:0] {
    CMD_APPEND = 2'd0,
    CMD_SHOW   = 2'd1,
    CMD_DELETE = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    ST_APPENDED  = 3'd0,
    ST_LISTED    = 3'd1,
    ST_DELETED   = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_FULL      = 3'd4,
    ST_EMPTY     = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    ELEM_VALUE = 2'd0,
    ELEM_READ  = 2'd1,
    ELEM_ZERO  = 2'd2
  } elem_sel_e;

  typedef struct packed {
    logic      latch;
    logic      rd_en;
    logic      wr_append;
    logic      wr_shift;
    logic      cnt_inc;
    logic      cnt_dec;
    logic      set_found;
    logic      emit;
    status_e   status;
    elem_sel_e elem_sel;
    logic      last;
  } dp_cmd_t;

  typedef struct packed {
    cmd_e cmd;
    logic full;
    logic empty;
    logic idx_end;
    logic rd_vld;
    logic rd_last;
    logic rd_match;
    logic found;
  } dp_stat_t;

endpackage

@@ rtl/core/olad_ctrl.sv @@
// Controller state machine for the ordered list.
module olad_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy_o,
  input  olad_pkg::dp_stat_t stat_i,
  output olad_pkg::dp_cmd_t  ctl_o
);
  import olad_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_DECODE = 3'b010,
    S_SCAN   = 3'b100
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);

  always_comb begin
    state_d  = state_q;
    ctl_o    = '0;
    ctl_o.status   = ST_APPENDED;
    ctl_o.elem_sel = ELEM_VALUE;
    ctl_o.last     = 1'b1;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          ctl_o.latch = 1'b1;
          state_d     = S_DECODE;
        end
      end
      S_DECODE: begin
        state_d = S_IDLE;
        case (stat_i.cmd)
          CMD_APPEND: begin
            ctl_o.emit = 1'b1;
            if (stat_i.full) begin
              ctl_o.status = ST_FULL;
            end else begin
              ctl_o.wr_append = 1'b1;
              ctl_o.cnt_inc   = 1'b1;
              ctl_o.status    = ST_APPENDED;
            end
          end
          CMD_SHOW: begin
            if (stat_i.empty) begin
              ctl_o.emit     = 1'b1;
              ctl_o.status   = ST_EMPTY;
              ctl_o.elem_sel = ELEM_ZERO;
            end else begin
              state_d = S_SCAN;
            end
          end
          CMD_DELETE: begin
            if (stat_i.empty) begin
              ctl_o.emit   = 1'b1;
              ctl_o.status = ST_NOT_FOUND;
            end else begin
              state_d = S_SCAN;
            end
          end
          default: begin
            state_d = S_IDLE;
          end
        endcase
      end
      S_SCAN: begin
        ctl_o.rd_en = !stat_i.idx_end;
        if (stat_i.rd_vld) begin
          if (stat_i.cmd == CMD_SHOW) begin
            ctl_o.emit     = 1'b1;
            ctl_o.status   = ST_LISTED;
            ctl_o.elem_sel = ELEM_READ;
            ctl_o.last     = stat_i.rd_last;
            if (stat_i.rd_last) begin
              state_d = S_IDLE;
            end
          end else begin
            ctl_o.wr_shift = stat_i.found;
            if (stat_i.rd_last) begin
              ctl_o.emit = 1'b1;
              state_d    = S_IDLE;
              if (stat_i.found || stat_i.rd_match) begin
                ctl_o.cnt_dec = 1'b1;
                ctl_o.status  = ST_DELETED;
              end else begin
                ctl_o.status = ST_NOT_FOUND;
              end
            end else if (!stat_i.found && stat_i.rd_match) begin
              ctl_o.set_found = 1'b1;
            end
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

@@ rtl/core/olad_dpath.sv @@
// Datapath for the ordered list: entry store, counters and result register.
module olad_dpath #(
  parameter int unsigned DEPTH = olad_pkg::OLAD_DEPTH
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic [1:0]                          command_i,
  input  logic signed [olad_pkg::DATA_W-1:0]  value_i,
  input  olad_pkg::dp_cmd_t                   ctl_i,
  output olad_pkg::dp_stat_t                  stat_o,
  output logic                                strobe_o,
  output logic [2:0]                          status_o,
  output logic signed [olad_pkg::DATA_W-1:0]  element_o,
  output logic                                last_o
);
  import olad_pkg::*;

  localparam int unsigned CntW  = $clog2(DEPTH + 1);
  localparam int unsigned AddrW = $clog2(DEPTH);

  logic [DATA_W-1:0] mem [DEPTH];

  cmd_e              cmd_q;
  logic [DATA_W-1:0] val_q;
  logic [CntW-1:0]   cnt_q;
  logic [CntW-1:0]   idx_q;
  logic [AddrW-1:0]  rd_idx_q;
  logic              rd_vld_q;
  logic [DATA_W-1:0] rd_data_q;
  logic              found_q;
  logic              strobe_q;
  status_e           status_q;
  logic [DATA_W-1:0] element_q;
  logic              last_q;
  logic [DATA_W-1:0] element_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      idx_q    <= '0;
      rd_vld_q <= 1'b0;
      found_q  <= 1'b0;
      strobe_q <= 1'b0;
    end else begin
      rd_vld_q <= ctl_i.rd_en;
      strobe_q <= ctl_i.emit;
      if (ctl_i.cnt_inc) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (ctl_i.cnt_dec) begin
        cnt_q <= cnt_q - 1'b1;
      end
      if (ctl_i.latch) begin
        idx_q <= '0;
      end else if (ctl_i.rd_en) begin
        idx_q <= idx_q + 1'b1;
      end
      if (ctl_i.latch) begin
        found_q <= 1'b0;
      end else if (ctl_i.set_found) begin
        found_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.latch) begin
      cmd_q <= cmd_e'(command_i);
      val_q <= value_i;
    end
    if (ctl_i.rd_en) begin
      rd_idx_q  <= idx_q[AddrW-1:0];
      rd_data_q <= mem[idx_q[AddrW-1:0]];
    end
    if (ctl_i.emit) begin
      status_q  <= ctl_i.status;
      element_q <= element_d;
      last_q    <= ctl_i.last;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_append) begin
      mem[cnt_q[AddrW-1:0]] <= val_q;
    end else if (ctl_i.wr_shift) begin
      mem[rd_idx_q - 1'b1] <= rd_data_q;
    end
  end

  always_comb begin
    case (ctl_i.elem_sel)
      ELEM_VALUE: element_d = val_q;
      ELEM_READ:  element_d = rd_data_q;
      ELEM_ZERO:  element_d = '0;
      default:    element_d = val_q;
    endcase
  end

  always_comb begin
    stat_o          = '0;
    stat_o.cmd      = cmd_q;
    stat_o.full     = (cnt_q == CntW'(DEPTH));
    stat_o.empty    = (cnt_q == '0);
    stat_o.idx_end  = (idx_q == cnt_q);
    stat_o.rd_vld   = rd_vld_q;
    stat_o.rd_last  = ((CntW'(rd_idx_q) + 1'b1) == cnt_q);
    stat_o.rd_match = (rd_data_q == val_q);
    stat_o.found    = found_q;
  end

  assign strobe_o  = strobe_q;
  assign status_o  = status_q;
  assign element_o = element_q;
  assign last_o    = last_q;

`include "ordered_list_append_delete_assert.svh"

  `OLAD_ASSERT_NEVER(a_cnt_bound, cnt_q > CntW'(DEPTH), "entry count above depth")
  `OLAD_ASSERT(a_append_room, ctl_i.cnt_inc |-> cnt_q < CntW'(DEPTH), "append into full list")
  `OLAD_ASSERT(a_shift_valid, ctl_i.wr_shift |-> rd_vld_q && found_q && rd_idx_q != '0,
               "shift without a prior match")
  `OLAD_ASSERT(a_cnt_dec, ctl_i.cnt_dec |=> cnt_q == $past(cnt_q) - 1'b1,
               "delete did not shrink list")

endmodule

@@ rtl/core/ordered_list_append_delete.sv @@
// Top level of the ordered list with append, show and delete by value.
// A request is taken when start is high and busy is low. Append, and show or delete on an
// empty list, are settled in the decode state; show or delete on a list with entries goes on
// to a scan that walks the entry store through its single read port, one entry per cycle.
// Each result is on the outputs for exactly one cycle under strobe_o and must be taken
// then: the receiver cannot stall. last_o marks the final result of a request; an unused
// command code yields no result.
module ordered_list_append_delete #(
  parameter int unsigned DEPTH = olad_pkg::OLAD_DEPTH
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start,
  output logic                               busy,
  input  logic [1:0]                         command_i,
  input  logic signed [olad_pkg::DATA_W-1:0] value_i,
  output logic                               strobe_o,
  output logic [2:0]                         status_o,
  output logic signed [olad_pkg::DATA_W-1:0] element_o,
  output logic                               last_o
);
  import olad_pkg::*;

  dp_cmd_t  ctl;
  dp_stat_t stat;

  olad_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy_o (busy),
    .stat_i (stat),
    .ctl_o  (ctl)
  );

  olad_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .command_i (command_i),
    .value_i   (value_i),
    .ctl_i     (ctl),
    .stat_o    (stat),
    .strobe_o  (strobe_o),
    .status_o  (status_o),
    .element_o (element_o),
    .last_o    (last_o)
  );

endmodule
